// ===== rtl/fmpsf_pkg.sv =====
`timescale 1ns / 1ps

package fmpsf_pkg;

  // Request types carried in req_type.
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_SUBJECT = 2'd2;

  // Response kinds carried in resp_kind.
  localparam logic [1:0] RESP_LOADED  = 2'd0;
  localparam logic [1:0] RESP_REMOVED = 2'd1;
  localparam logic [1:0] RESP_MATCH   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Input beat payload.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] char_value;
    logic        last;
    logic [31:0] op_flags;
    logic [2:0]  slot;
  } in_item_t;

  // Result beat payload.
  typedef struct packed {
    logic [1:0] resp_kind;
    logic [1:0] status;
    logic [2:0] slot_out;
    logic       matched;
  } out_item_t;

endpackage

// ===== rtl/flagged_multi_pattern_substring_filter.sv =====
`timescale 1ns / 1ps

// Flagged multi-pattern substring filter. Patterns of 16-bit characters are
// loaded one character per beat into the lowest free slot, removed by slot
// number, and each carries a 32-bit flag word. Subject characters stream in
// one per beat, are lowercased (A-Z only) and are checked against every valid
// pattern at once with shift-and progress vectors; the last subject beat
// returns whether a pattern whose flags overlap the query mask occurred. The
// block takes one beat every cycle unless stalled: each beat lands in an input
// register, and once the result register is free all stored pattern positions
// are compared in parallel and the state and result register are updated.
// Only the last beat of a load, every remove and the last beat of a subject
// produce a result. The input stalls only while a finished result waits on a
// stalled output.
module flagged_multi_pattern_substring_filter #(
  parameter int NUM_PATTERNS = 8,
  parameter int PATTERN_LEN  = 32,
  parameter int SUBJECT_MAX  = 259
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmpsf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fmpsf_pkg::out_item_t out_item
);
  import fmpsf_pkg::*;

  localparam int SW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int IW = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
  localparam int LW = $clog2(PATTERN_LEN + 1);
  localparam int CW = $clog2(SUBJECT_MAX + 1);

  // Pattern storage and per-pattern state.
  logic [15:0]                               chars_r [NUM_PATTERNS][PATTERN_LEN];
  logic [NUM_PATTERNS-1:0][LW-1:0]           len_r, len_nxt;
  logic [NUM_PATTERNS-1:0][31:0]             flags_r, flags_nxt;
  logic [NUM_PATTERNS-1:0]                   valid_r, valid_nxt;
  logic [NUM_PATTERNS-1:0][PATTERN_LEN-1:0]  pv_r, pv_nxt;
  logic [NUM_PATTERNS-1:0]                   hit_r, hit_nxt;

  // Load tracking.
  logic          load_busy_r, load_busy_nxt;
  logic          load_has_r, load_has_nxt;
  logic [SW-1:0] load_slot_r, load_slot_nxt;
  logic [LW-1:0] load_cnt_r, load_cnt_nxt;
  logic          load_ended_r, load_ended_nxt;
  logic          load_trunc_r, load_trunc_nxt;

  // Subject tracking.
  logic [CW-1:0] subj_cnt_r, subj_cnt_nxt;
  logic          subj_ended_r, subj_ended_nxt;
  logic          subj_trunc_r, subj_trunc_nxt;

  // Input and output registers.
  logic      stage_v_r, stage_v_nxt;
  in_item_t  stage_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic          can_proc, do_proc, in_accept;
  logic [15:0]   subj_char;
  logic [NUM_PATTERNS-1:0][PATTERN_LEN-1:0] feed_pv;
  logic [NUM_PATTERNS-1:0]                  feed_hit;
  logic [NUM_PATTERNS-1:0][LW-1:0]          len_m1;
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic          ld_has, ld_end, ld_trunc;
  logic [SW-1:0] ld_slot;
  logic [LW-1:0] ld_cnt;
  logic          wr_en;
  logic          rm_ok;
  logic [SW-1:0] rm_idx;
  logic          any_match;
  logic [6:0]    slot_ext;

  // Handshake: the staged beat is processed when the result register is free.
  assign can_proc  = !out_valid_r || !out_stall;
  assign do_proc   = stage_v_r && can_proc;
  assign in_stall  = stage_v_r && !can_proc;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Lowercase the subject character (A-Z only).
  assign subj_char = (stage_item_r.char_value >= 16'h0041 &&
                      stage_item_r.char_value <= 16'h005A) ?
                     stage_item_r.char_value + 16'h0020 : stage_item_r.char_value;

  // Shift-and step of every pattern against the current subject character.
  always_comb begin
    logic [PATTERN_LEN-1:0] eq;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      eq = '0;
      for (int j = 0; j < PATTERN_LEN; j++) begin
        eq[j] = (LW'(j) < len_r[p]) && (chars_r[p][j] == subj_char);
      end
      len_m1[p]   = len_r[p] - LW'(1);
      feed_pv[p]  = ((pv_r[p] << 1) | PATTERN_LEN'(1)) & eq;
      feed_hit[p] = hit_r[p] | feed_pv[p][len_m1[p][IW-1:0]];
    end
  end

  // Lowest slot that holds no valid pattern.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (!valid_r[p]) begin
        free_found = 1'b1;
        free_slot  = SW'(p);
      end
    end
  end

  // Load context for this beat: a fresh load claims the free slot.
  assign ld_has   = load_busy_r ? load_has_r   : free_found;
  assign ld_slot  = load_busy_r ? load_slot_r  : free_slot;
  assign ld_cnt   = load_busy_r ? load_cnt_r   : '0;
  assign ld_end   = load_busy_r && load_ended_r;
  assign ld_trunc = load_busy_r && load_trunc_r;
  assign slot_ext = 7'(ld_slot);

  // Remove target check.
  assign rm_idx = SW'(stage_item_r.slot);
  assign rm_ok  = (7'(stage_item_r.slot) < 7'(NUM_PATTERNS)) && valid_r[rm_idx];

  // Next-state and result logic for the staged beat.
  always_comb begin
    len_nxt        = len_r;
    flags_nxt      = flags_r;
    valid_nxt      = valid_r;
    pv_nxt         = pv_r;
    hit_nxt        = hit_r;
    load_busy_nxt  = load_busy_r;
    load_has_nxt   = load_has_r;
    load_slot_nxt  = load_slot_r;
    load_cnt_nxt   = load_cnt_r;
    load_ended_nxt = load_ended_r;
    load_trunc_nxt = load_trunc_r;
    subj_cnt_nxt   = subj_cnt_r;
    subj_ended_nxt = subj_ended_r;
    subj_trunc_nxt = subj_trunc_r;
    wr_en          = 1'b0;
    any_match      = 1'b0;
    out_item_nxt   = out_item_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (do_proc) begin
      unique case (stage_item_r.req_type)
        REQ_LOAD: begin
          load_busy_nxt  = 1'b1;
          load_has_nxt   = ld_has;
          load_slot_nxt  = ld_slot;
          load_cnt_nxt   = ld_cnt;
          load_ended_nxt = ld_end;
          load_trunc_nxt = ld_trunc;
          if (ld_has && !ld_end) begin
            if (stage_item_r.char_value == 16'h0000) begin
              load_ended_nxt = 1'b1;
            end else if (ld_cnt < LW'(PATTERN_LEN)) begin
              wr_en        = 1'b1;
              load_cnt_nxt = ld_cnt + LW'(1);
            end else begin
              load_trunc_nxt = 1'b1;
            end
          end
          if (stage_item_r.last) begin
            out_valid_nxt          = 1'b1;
            out_item_nxt.resp_kind = RESP_LOADED;
            out_item_nxt.matched   = 1'b0;
            if (ld_has) begin
              len_nxt[ld_slot]      = load_cnt_nxt;
              flags_nxt[ld_slot]    = stage_item_r.op_flags;
              valid_nxt[ld_slot]    = 1'b1;
              pv_nxt[ld_slot]       = '0;
              hit_nxt[ld_slot]      = 1'b0;
              out_item_nxt.status   = load_trunc_nxt ? ST_TRUNC : ST_OK;
              out_item_nxt.slot_out = slot_ext[2:0];
            end else begin
              out_item_nxt.status   = ST_FULL;
              out_item_nxt.slot_out = 3'd0;
            end
            load_busy_nxt = 1'b0;
            load_has_nxt  = 1'b0;
          end
        end
        REQ_REMOVE: begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.resp_kind = RESP_REMOVED;
          out_item_nxt.slot_out  = stage_item_r.slot;
          out_item_nxt.matched   = 1'b0;
          if (rm_ok) begin
            valid_nxt[rm_idx]   = 1'b0;
            pv_nxt[rm_idx]      = '0;
            hit_nxt[rm_idx]     = 1'b0;
            out_item_nxt.status = ST_OK;
          end else begin
            out_item_nxt.status = ST_EMPTY;
          end
        end
        REQ_SUBJECT: begin
          if (!subj_ended_r) begin
            if (stage_item_r.char_value == 16'h0000) begin
              subj_ended_nxt = 1'b1;
            end else if (subj_cnt_r < CW'(SUBJECT_MAX)) begin
              for (int p = 0; p < NUM_PATTERNS; p++) begin
                if (valid_r[p] && len_r[p] != '0) begin
                  pv_nxt[p]  = feed_pv[p];
                  hit_nxt[p] = feed_hit[p];
                end
              end
              subj_cnt_nxt = subj_cnt_r + CW'(1);
            end else begin
              subj_trunc_nxt = 1'b1;
            end
          end
          if (stage_item_r.last) begin
            for (int p = 0; p < NUM_PATTERNS; p++) begin
              if (valid_r[p] && (flags_r[p] & stage_item_r.op_flags) != 32'd0 &&
                  (len_r[p] == '0 || hit_nxt[p])) begin
                any_match = 1'b1;
              end
            end
            out_valid_nxt          = 1'b1;
            out_item_nxt.resp_kind = RESP_MATCH;
            out_item_nxt.status    = subj_trunc_nxt ? ST_TRUNC : ST_OK;
            out_item_nxt.slot_out  = 3'd0;
            out_item_nxt.matched   = any_match;
            pv_nxt         = '0;
            hit_nxt        = '0;
            subj_cnt_nxt   = '0;
            subj_ended_nxt = 1'b0;
            subj_trunc_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stage_v_nxt = in_accept ? 1'b1 : (do_proc ? 1'b0 : stage_v_r);

  // Control and per-pattern state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      flags_r      <= '0;
      valid_r      <= '0;
      pv_r         <= '0;
      hit_r        <= '0;
      load_busy_r  <= 1'b0;
      load_has_r   <= 1'b0;
      load_slot_r  <= '0;
      load_cnt_r   <= '0;
      load_ended_r <= 1'b0;
      load_trunc_r <= 1'b0;
      subj_cnt_r   <= '0;
      subj_ended_r <= 1'b0;
      subj_trunc_r <= 1'b0;
      stage_v_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      flags_r      <= flags_nxt;
      valid_r      <= valid_nxt;
      pv_r         <= pv_nxt;
      hit_r        <= hit_nxt;
      load_busy_r  <= load_busy_nxt;
      load_has_r   <= load_has_nxt;
      load_slot_r  <= load_slot_nxt;
      load_cnt_r   <= load_cnt_nxt;
      load_ended_r <= load_ended_nxt;
      load_trunc_r <= load_trunc_nxt;
      subj_cnt_r   <= subj_cnt_nxt;
      subj_ended_r <= subj_ended_nxt;
      subj_trunc_r <= subj_trunc_nxt;
      stage_v_r    <= stage_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers and pattern character storage.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
    if (wr_en) begin
      chars_r[ld_slot][ld_cnt[IW-1:0]] <= stage_item_r.char_value;
    end
  end

  // Progress vectors of slots without a valid pattern must stay clear.
  logic pv_leak;
  always_comb begin
    pv_leak = 1'b0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if (!valid_r[p] && pv_r[p] != '0) begin
        pv_leak = 1'b1;
      end
    end
  end

  // A completed load never lands on a slot that is already valid.
  a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (do_proc && stage_item_r.req_type == REQ_LOAD && stage_item_r.last && ld_has)
    |-> !valid_r[ld_slot])
    else $error("load completed on an occupied slot");

  // Invalid slots carry no subject progress.
  a_no_pv_leak: assert property (@(posedge clk) disable iff (!rst_n) !pv_leak)
    else $error("progress vector set on an invalid slot");

  // A match answer leaves the subject state cleared.
  a_subject_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (do_proc && stage_item_r.req_type == REQ_SUBJECT && stage_item_r.last)
    |=> (subj_cnt_r == '0 && !subj_ended_r && !subj_trunc_r && hit_r == '0))
    else $error("subject state not cleared after answer");

  // A new result only appears after a staged beat was processed.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(do_proc))
    else $error("result appeared without a processed beat");

  // The subject counter never runs past its limit.
  a_subject_bound: assert property (@(posedge clk) disable iff (!rst_n)
    subj_cnt_r <= CW'(SUBJECT_MAX))
    else $error("subject counter overflow");

endmodule

// ===== bench/tb_flagged_multi_pattern_substring_filter.sv =====
`timescale 1ns / 1ps

module tb_flagged_multi_pattern_substring_filter;
  import fmpsf_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int PAT_MAX   = 32;
  localparam int SUBJ_MAX  = 259;

  // Character constants for the A-Z case fold.
  localparam logic [15:0] CHAR_UP_A   = 16'h0041;
  localparam logic [15:0] CHAR_UP_Z   = 16'h005A;
  localparam logic [15:0] CHAR_LOW_A  = 16'h0061;
  localparam logic [15:0] CASE_OFFSET = 16'h0020;
  localparam logic [15:0] CHAR_END    = 16'h0000;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  flagged_multi_pattern_substring_filter #(
    .NUM_PATTERNS(NUM_SLOTS),
    .PATTERN_LEN (PAT_MAX),
    .SUBJECT_MAX (SUBJ_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Shadow copy of the pattern table and the match progress.
  logic [15:0] pat_char [NUM_SLOTS][PAT_MAX];
  int          pat_len [NUM_SLOTS];
  logic [31:0] pat_flags [NUM_SLOTS];
  bit          pat_on [NUM_SLOTS];
  logic [31:0] shift_vec [NUM_SLOTS];
  bit          pat_seen [NUM_SLOTS];

  bit ld_active, ld_has_slot, ld_stopped, ld_dropped;
  int ld_slot, ld_count;
  bit subj_stopped, subj_dropped;
  int subj_count;

  out_item_t expected_responses[$];

  int error_count = 0;
  int responses_checked = 0;
  int beats_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the response, if any, that an accepted beat causes.
  function automatic void predict_response(in_item_t it);
    out_item_t   r;
    logic [31:0] eq;
    logic [15:0] c;
    bit          any;
    int          p, j;
    r = '0;
    case (it.req_type)
      REQ_LOAD: begin
        // The first beat of a load claims the lowest free slot.
        if (!ld_active) begin
          ld_active = 1;
          ld_has_slot = 0;
          ld_count = 0;
          ld_stopped = 0;
          ld_dropped = 0;
          for (p = 0; p < NUM_SLOTS; p++) begin
            if (!ld_has_slot && !pat_on[p]) begin
              ld_has_slot = 1;
              ld_slot = p;
              shift_vec[p] = '0;
              pat_seen[p] = 0;
            end
          end
        end
        if (ld_has_slot && !ld_stopped) begin
          if (it.char_value == CHAR_END) begin
            ld_stopped = 1;
          end else if (ld_count < PAT_MAX) begin
            pat_char[ld_slot][ld_count] = it.char_value;
            ld_count++;
          end else begin
            ld_dropped = 1;
          end
        end
        if (it.last) begin
          r.resp_kind = RESP_LOADED;
          if (ld_has_slot) begin
            pat_len[ld_slot] = ld_count;
            pat_flags[ld_slot] = it.op_flags;
            pat_on[ld_slot] = 1;
            shift_vec[ld_slot] = '0;
            pat_seen[ld_slot] = 0;
            r.status = ld_dropped ? ST_TRUNC : ST_OK;
            r.slot_out = ld_slot[2:0];
          end else begin
            r.status = ST_FULL;
          end
          ld_active = 0;
          ld_has_slot = 0;
          expected_responses.push_back(r);
        end
      end
      REQ_REMOVE: begin
        r.resp_kind = RESP_REMOVED;
        r.slot_out = it.slot;
        if (pat_on[it.slot]) begin
          pat_on[it.slot] = 0;
          shift_vec[it.slot] = '0;
          pat_seen[it.slot] = 0;
          r.status = ST_OK;
        end else begin
          r.status = ST_EMPTY;
        end
        expected_responses.push_back(r);
      end
      REQ_SUBJECT: begin
        if (!subj_stopped) begin
          if (it.char_value == CHAR_END) begin
            subj_stopped = 1;
          end else if (subj_count < SUBJ_MAX) begin
            // Fold A-Z to lower case, then advance every shift-and vector.
            c = it.char_value;
            if (c >= CHAR_UP_A && c <= CHAR_UP_Z) c = c + CASE_OFFSET;
            for (p = 0; p < NUM_SLOTS; p++) begin
              if (pat_on[p] && pat_len[p] != 0) begin
                eq = '0;
                for (j = 0; j < pat_len[p]; j++)
                  if (pat_char[p][j] == c) eq[j] = 1'b1;
                shift_vec[p] = ((shift_vec[p] << 1) | 32'd1) & eq;
                if (shift_vec[p][pat_len[p] - 1]) pat_seen[p] = 1;
              end
            end
            subj_count++;
          end else begin
            subj_dropped = 1;
          end
        end
        if (it.last) begin
          any = 0;
          for (p = 0; p < NUM_SLOTS; p++)
            if (pat_on[p] && (pat_flags[p] & it.op_flags) != '0 &&
                (pat_len[p] == 0 || pat_seen[p]))
              any = 1;
          r.resp_kind = RESP_MATCH;
          r.status = subj_dropped ? ST_TRUNC : ST_OK;
          r.matched = any;
          expected_responses.push_back(r);
          for (p = 0; p < NUM_SLOTS; p++) begin
            shift_vec[p] = '0;
            pat_seen[p] = 0;
          end
          subj_count = 0;
          subj_stopped = 0;
          subj_dropped = 0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= 50)
      $display("%0t ERROR %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Compare one accepted result beat with the oldest expected response.
  task automatic check_response(out_item_t got);
    out_item_t want;
    responses_checked++;
    if (expected_responses.size() == 0) begin
      report_mismatch("response with nothing expected", 32'(got), 32'd0);
      return;
    end
    want = expected_responses.pop_front();
    if (got.resp_kind !== want.resp_kind)
      report_mismatch("resp_kind", 32'(got.resp_kind), 32'(want.resp_kind));
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.slot_out !== want.slot_out)
      report_mismatch("slot_out", 32'(got.slot_out), 32'(want.slot_out));
    if (got.matched !== want.matched)
      report_mismatch("matched", 32'(got.matched), 32'(want.matched));
  endtask

  // Result side: check accepted beats and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_response(out_item);
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one beat, with random idle cycles ahead of it, and wait for it to go in.
  task automatic send_beat(in_item_t it);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predict_response(it);
    if (it.req_type != REQ_UNUSED) beats_sent++;
  endtask

  // Stop offering beats and let every expected response come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_item_t mk_beat(logic [1:0] rt, logic [15:0] ch, logic lst,
                                       logic [31:0] fl, logic [2:0] sl);
    in_item_t b;
    b.req_type = rt;
    b.char_value = ch;
    b.last = lst;
    b.op_flags = fl;
    b.slot = sl;
    return b;
  endfunction

  // Characters cluster on a few letters so that matches are frequent.
  function automatic logic [15:0] pick_char(bit for_subject);
    logic [15:0] edges [8] = '{16'h0040, 16'h0041, 16'h005A, 16'h005B,
                               16'h0060, 16'h0061, 16'h007A, 16'h007B};
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return CHAR_END;
    if (r < (for_subject ? 55 : 80)) return CHAR_LOW_A + 16'($urandom_range(0, 3));
    if (r < 88) return CHAR_UP_A + 16'($urandom_range(0, 3));
    if (r < 94) return edges[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_flag_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'd1 << $urandom_range(0, 3);
    if (r < 70) return $urandom;
    if (r < 85) return '0;
    return '1;
  endfunction

  // Send a pattern of len characters; a cut sequence is left open.
  task automatic send_pattern(int len, logic [31:0] flags, bit cut);
    bit lst;
    int i;
    if (len == 0) begin
      send_beat(mk_beat(REQ_LOAD, CHAR_END, !cut, flags, 3'($urandom)));
      return;
    end
    for (i = 0; i < len; i++) begin
      lst = (i == len - 1) && !cut;
      send_beat(mk_beat(REQ_LOAD, pick_char(0), lst, lst ? flags : $urandom,
                        3'($urandom)));
    end
  endtask

  task automatic send_subject(int len, logic [31:0] mask, bit cut);
    bit lst;
    int i;
    for (i = 0; i < len; i++) begin
      lst = (i == len - 1) && !cut;
      send_beat(mk_beat(REQ_SUBJECT, pick_char(1), lst, lst ? mask : $urandom,
                        3'($urandom)));
    end
  endtask

  // Extremes, every request type and the special cases, in short beats.
  task automatic test_directed();
    // Pattern "ab" with every flag set goes to slot 0.
    send_beat(mk_beat(REQ_LOAD, 16'("a"), 1'b0, '0, '0));
    send_beat(mk_beat(REQ_LOAD, 16'("b"), 1'b1, '1, '1));
    // A zero ends the pattern; the trailing character is ignored.
    send_beat(mk_beat(REQ_LOAD, 16'("x"), 1'b0, '1, '0));
    send_beat(mk_beat(REQ_LOAD, CHAR_END, 1'b0, '1, '0));
    send_beat(mk_beat(REQ_LOAD, 16'("y"), 1'b1, 32'h0000_0001, '0));
    // Empty pattern, top flag bit only.
    send_beat(mk_beat(REQ_LOAD, CHAR_END, 1'b1, 32'h8000_0000, '0));
    // Upper-case pattern is stored as given and never matches.
    send_beat(mk_beat(REQ_LOAD, 16'("Q"), 1'b1, 32'h0000_0002, '0));
    // Upper-case subject folds onto "ab".
    send_beat(mk_beat(REQ_SUBJECT, 16'("Z"), 1'b0, '0, '0));
    send_beat(mk_beat(REQ_SUBJECT, 16'("A"), 1'b0, '0, '0));
    send_beat(mk_beat(REQ_SUBJECT, 16'("b"), 1'b1, 32'hFFFF_FFFE, '0));
    send_beat(mk_beat(REQ_SUBJECT, 16'("q"), 1'b1, 32'h0000_0002, '0));
    // A zero ends the subject before "b" arrives.
    send_beat(mk_beat(REQ_SUBJECT, 16'("a"), 1'b0, '0, '0));
    send_beat(mk_beat(REQ_SUBJECT, CHAR_END, 1'b0, '0, '0));
    send_beat(mk_beat(REQ_SUBJECT, 16'("b"), 1'b1, 32'h7FFF_FFFF, '0));
    // Remove an empty slot, then the empty pattern.
    send_beat(mk_beat(REQ_REMOVE, '1, 1'b1, '1, 3'd7));
    send_beat(mk_beat(REQ_REMOVE, '0, 1'b0, '0, 3'd2));
    // Unused request type is ignored.
    send_beat(mk_beat(REQ_UNUSED, '1, 1'b1, '1, '1));
    // Pattern made valid mid-subject sees only later characters.
    send_beat(mk_beat(REQ_SUBJECT, 16'("c"), 1'b0, '0, '0));
    send_beat(mk_beat(REQ_LOAD, 16'("c"), 1'b0, '0, '0));
    send_beat(mk_beat(REQ_LOAD, 16'("d"), 1'b1, 32'h0000_0004, '0));
    send_beat(mk_beat(REQ_SUBJECT, 16'("d"), 1'b1, 32'h0000_0004, '0));
    // Removing the slot that is still loading reports it empty.
    send_beat(mk_beat(REQ_LOAD, 16'hFFFF, 1'b0, '0, '0));
    send_beat(mk_beat(REQ_REMOVE, '0, 1'b0, '0, 3'd4));
    send_beat(mk_beat(REQ_LOAD, 16'("f"), 1'b1, '0, '0));
    drain();
  endtask

  // Over-long pattern and subject, next to a pattern of exactly full length.
  task automatic test_truncation();
    int i;
    for (i = 0; i < NUM_SLOTS; i++)
      send_beat(mk_beat(REQ_REMOVE, '0, 1'b0, '0, 3'(i)));
    for (i = 0; i < PAT_MAX; i++)
      send_beat(mk_beat(REQ_LOAD, CHAR_LOW_A + 16'(i % 4), i == PAT_MAX - 1, '1, '0));
    for (i = 0; i < PAT_MAX + 1; i++)
      send_beat(mk_beat(REQ_LOAD, CHAR_LOW_A + 16'(i % 3), i == PAT_MAX, '1, '0));
    for (i = 0; i < SUBJ_MAX + 1; i++)
      send_beat(mk_beat(REQ_SUBJECT, CHAR_UP_A + 16'(i % 4), i == SUBJ_MAX, '1, '0));
    drain();
  endtask

  // Mostly well-formed loads, removes and subjects; some noise and cut sequences.
  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    int start, kind, r, p, len;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = beats_sent;
    while (beats_sent - start < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        r = $urandom_range(0, 99);
        len = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 4) :
              (r < 97) ? $urandom_range(5, 10) : $urandom_range(30, 36);
        send_pattern(len, pick_flag_word(), $urandom_range(0, 19) == 0);
      end else if (kind < 48) begin
        // Usually aim at a slot in use.
        p = $urandom_range(0, NUM_SLOTS - 1);
        if ($urandom_range(0, 9) < 7)
          for (r = 0; r < NUM_SLOTS && !pat_on[p]; r++) p = (p + 1) % NUM_SLOTS;
        send_beat(mk_beat(REQ_REMOVE, 16'($urandom), 1'($urandom), $urandom, 3'(p)));
      end else if (kind < 93) begin
        len = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        send_subject(len, pick_flag_word(), $urandom_range(0, 19) == 0);
      end else begin
        send_beat(mk_beat(2'($urandom), 16'($urandom), 1'($urandom), $urandom,
                          3'($urandom)));
      end
    end
    drain();
  endtask

  // Test sequence.
  initial begin
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      pat_len[i] = 0;
      pat_flags[i] = '0;
      pat_on[i] = 0;
      shift_vec[i] = '0;
      pat_seen[i] = 0;
    end
    ld_active = 0;
    ld_has_slot = 0;
    ld_stopped = 0;
    ld_dropped = 0;
    ld_slot = 0;
    ld_count = 0;
    subj_stopped = 0;
    subj_dropped = 0;
    subj_count = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_truncation();
    test_random_phase(110, 0, 0);
    test_random_phase(110, 80, 0);
    test_random_phase(110, 0, 80);
    test_random_phase(110, 9, 9);

    $display("Covered directed cases, truncation and four idle/stall mixes:");
    $display("%0d beats sent, %0d responses checked.", beats_sent, responses_checked);
    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Timed out with %0d responses outstanding.", expected_responses.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
